// ===== hw/rtl/gse_pkg.sv =====
// shared types, constants and character helpers for the sequence extractor
`timescale 1ns / 1ps

package gse_pkg;

  localparam int unsigned DefQueueDepth = 4;
  localparam int unsigned MaxBeats = 3;
  localparam int unsigned KeywordLen = 6;

  // token phase codes
  localparam logic [2:0] PhBetween = 3'd0;
  localparam logic [2:0] PhEmit = 3'd1;
  localparam logic [2:0] PhSkip = 3'd2;
  localparam logic [2:0] PhSlash1 = 3'd3;
  localparam logic [2:0] PhSlash2 = 3'd4;

  localparam logic [7:0] ChSlash = 8'h2f;

  // one classified input byte, expanded into 1 to 3 output beats
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MaxBeats-1:0][7:0]     res;
    logic [MaxBeats-1:0]          vld;
    logic                         done;
    logic                         empty;
  } cmd_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if ((c >= 8'h61) && (c <= 8'h7a)) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // characters of the keyword ORIGIN
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h4f;
      3'd1: ch = 8'h52;
      3'd2: ch = 8'h49;
      3'd3: ch = 8'h47;
      3'd4: ch = 8'h49;
      3'd5: ch = 8'h4e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/genbank_sequence_extractor_core.sv =====
// top level of the sequence extractor: front scanner, command queue, beat expander
// timing: with the queue empty, the first result beat of a byte is offered the cycle after
//   the byte is accepted; beats of queued commands ahead of it are sent first
// throughput: one byte per cycle; the output moves one beat per cycle while m_axis_tready is
//   high, so bytes giving two or three beats (held slashes plus a character) are absorbed by
//   the QueueDepth-entry command queue; input stalls only when that queue is full
// reset: rst_ni is asynchronous, active low; returns to keyword seeking, empties queue
`timescale 1ns / 1ps

module genbank_sequence_extractor_core #(
  parameter int unsigned QueueDepth = gse_pkg::DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_input
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] residue
  output logic       m_axis_tlast,   // record_done
  output logic [2:0] m_axis_tuser    // [0] residue_valid, [1] record_empty, [2] last_of_run
);
  import gse_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  // a byte is taken whenever the queue has room, even while results wait
  assign s_axis_tready = !full;
  assign accept = s_axis_tvalid && s_axis_tready;

  // classify the byte and build the beats it causes
  gse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (s_axis_tdata),
    .end_of_input_i (s_axis_tlast),
    .push_o         (push),
    .cmd_o          (cmd_in)
  );

  // decouples the scanner from output backpressure
  gse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .pop_i   (pop),
    .rdata_o (cmd_head),
    .full_o  (full),
    .empty_o (empty)
  );

  // walk the head command one beat per handshake
  gse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_head),
    .avail_i       (!empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hw/rtl/gse_front.sv =====
// tokenizer and keyword scanner, turns each byte into at most one queue command
`timescale 1ns / 1ps

module gse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_input_i,
  output logic          push_o,
  output gse_pkg::cmd_t cmd_o
);
  import gse_pkg::*;

  logic       mode_q, mode_d;
  logic [2:0] phase_q, phase_d;
  logic [2:0] prog_q, prog_d;
  logic       broken_q, broken_d;
  logic       seen_q, seen_d;

  always_comb begin
    logic       ws;
    logic       closed;
    logic [1:0] n;
    logic [7:0] uc;
    cmd_t       cmd;

    ws = is_space(data_byte_i);
    uc = upcase(data_byte_i);
    closed = 1'b0;
    n = 2'd0;
    cmd = '0;
    mode_d = mode_q;
    phase_d = phase_q;
    prog_d = prog_q;
    broken_d = broken_q;
    seen_d = seen_q;

    if (!mode_q) begin
      if (ws) begin
        if ((prog_q == 3'(KeywordLen)) && !broken_q) begin
          mode_d = 1'b1;
          phase_d = PhBetween;
          seen_d = 1'b0;
        end
        prog_d = '0;
        broken_d = 1'b0;
      end else if (!broken_q && (prog_q < 3'(KeywordLen)) &&
                   (data_byte_i == kw_char(prog_q))) begin
        prog_d = prog_q + 3'd1;
      end else begin
        broken_d = 1'b1;
      end
      if (end_of_input_i) begin
        cmd.done = 1'b1;
        cmd.empty = 1'b1;
        n = 2'd1;
        closed = 1'b1;
      end
    end else begin
      case (phase_q)
        PhEmit: begin
          if (ws) begin
            phase_d = PhBetween;
          end else begin
            cmd.res[n] = uc;
            cmd.vld[n] = 1'b1;
            n = n + 2'd1;
            seen_d = 1'b1;
          end
        end
        PhSkip: begin
          if (ws) begin
            phase_d = PhBetween;
          end
        end
        PhSlash1: begin
          if (ws) begin
            cmd.res[n] = ChSlash;
            cmd.vld[n] = 1'b1;
            n = n + 2'd1;
            seen_d = 1'b1;
            phase_d = PhBetween;
          end else if (data_byte_i == ChSlash) begin
            phase_d = PhSlash2;
          end else begin
            cmd.res[0] = ChSlash;
            cmd.vld[0] = 1'b1;
            cmd.res[1] = uc;
            cmd.vld[1] = 1'b1;
            n = 2'd2;
            seen_d = 1'b1;
            phase_d = PhEmit;
          end
        end
        PhSlash2: begin
          if (ws) begin
            // closing // token
            cmd.done = 1'b1;
            cmd.empty = !seen_q;
            n = 2'd1;
            closed = 1'b1;
          end else begin
            cmd.res[0] = ChSlash;
            cmd.vld[0] = 1'b1;
            cmd.res[1] = ChSlash;
            cmd.vld[1] = 1'b1;
            cmd.res[2] = uc;
            cmd.vld[2] = 1'b1;
            n = 2'd3;
            seen_d = 1'b1;
            phase_d = PhEmit;
          end
        end
        default: begin
          if (ws) begin
            phase_d = PhBetween;
          end else if (is_digit(data_byte_i)) begin
            phase_d = PhSkip;
          end else if (data_byte_i == ChSlash) begin
            phase_d = PhSlash1;
          end else begin
            cmd.res[n] = uc;
            cmd.vld[n] = 1'b1;
            n = n + 2'd1;
            seen_d = 1'b1;
            phase_d = PhEmit;
          end
        end
      endcase

      if (end_of_input_i && !closed) begin
        // a lone held slash is flushed as a residue
        if (phase_d == PhSlash1) begin
          cmd.res[n] = ChSlash;
          cmd.vld[n] = 1'b1;
          n = n + 2'd1;
          seen_d = 1'b1;
        end
        cmd.done = 1'b1;
        if (n != 2'd0) begin
          cmd.empty = 1'b0;
        end else begin
          cmd.empty = !seen_d;
          n = 2'd1;
        end
        closed = 1'b1;
      end
    end

    // record closed: back to the reset state
    if (closed) begin
      mode_d = 1'b0;
      phase_d = PhBetween;
      prog_d = '0;
      broken_d = 1'b0;
      seen_d = 1'b0;
    end

    cmd.cnt = n;
    cmd_o = cmd;
    push_o = accept_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      phase_q <= PhBetween;
      prog_q <= '0;
      broken_q <= 1'b0;
      seen_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      phase_q <= phase_d;
      prog_q <= prog_d;
      broken_q <= broken_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== hw/rtl/gse_queue.sv =====
// small register queue of commands between the front and back parts
`timescale 1ns / 1ps

module gse_queue #(
  parameter int unsigned Depth = gse_pkg::DefQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gse_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output gse_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import gse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/gse_back.sv =====
// expands one queued command into its output beats
`timescale 1ns / 1ps

module gse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gse_pkg::cmd_t cmd_i,
  input  logic          avail_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,
  output logic          m_axis_tlast,
  output logic [2:0]    m_axis_tuser
);
  import gse_pkg::*;

  logic [1:0] beat_q, beat_d;
  logic       last_beat;
  logic       xfer;

  assign last_beat = (beat_q == (cmd_i.cnt - 2'd1));
  assign xfer = m_axis_tvalid && m_axis_tready;
  assign pop_o = xfer && last_beat;

  assign m_axis_tvalid = avail_i;
  assign m_axis_tdata = cmd_i.res[beat_q];
  assign m_axis_tlast = cmd_i.done && last_beat;
  assign m_axis_tuser = {last_beat, cmd_i.empty && last_beat, cmd_i.vld[beat_q]};

  always_comb begin
    beat_d = beat_q;
    if (xfer) begin
      beat_d = last_beat ? 2'd0 : beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 2'd0;
    end else begin
      beat_q <= beat_d;
    end
  end

endmodule
